/* hw/rtl/dae_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the DNS answer address extractor.
// No dependencies; imported by the parser, the result queue and the top level.
package dae_pkg;

  // Fixed layout of a DNS message
  localparam int unsigned HdrLen   = 12;
  localparam int unsigned QFixLen  = 4;
  localparam int unsigned AFixLen  = 10;
  localparam logic [15:0] TypeV4   = 16'd1;
  localparam logic [15:0] TypeV6   = 16'd28;
  localparam logic [15:0] LenV4    = 16'd4;
  localparam logic [15:0] LenV6    = 16'd16;
  localparam logic [7:0]  PtrMask  = 8'hC0;

  // Result queue depth; input is accepted only while two slots are free for a byte in flight
  localparam int unsigned OutDepth = 4;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_QNAME,
    PH_QPTR,
    PH_QFIXED,
    PH_ANAME,
    PH_APTR,
    PH_AFIXED,
    PH_RDATA,
    PH_DONE,
    PH_IGNORE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_V4     = 2'd0,
    KIND_V6     = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT_HDR   = 3'd1,
    ST_ID_MISMATCH = 3'd2,
    ST_BAD_QUEST   = 3'd3,
    ST_ANSWER_CUT  = 3'd4
  } status_e;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [2:0]  status;
    logic [15:0] address_count;
    logic        last;
  } res_t;

  // Up to two results caused by one byte, in order
  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } push_t;

endpackage

/* hw/rtl/dae_in_if.sv */
`timescale 1ns / 1ps
// Input byte channel: valid/ready handshake with one response byte per transfer.
// No dependencies.
interface dae_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [15:0] expected_id;

  modport source (output valid, output data_byte, output last_byte, output expected_id,
                  input ready);
  modport sink   (input valid, input data_byte, input last_byte, input expected_id,
                  output ready);
endinterface

/* hw/rtl/dae_out_if.sv */
`timescale 1ns / 1ps
// Result channel: valid/ready handshake, one address or status result per transfer.
// No dependencies.
interface dae_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] address_high;
  logic [63:0] address_low;
  logic [2:0]  status;
  logic [15:0] address_count;
  logic        last;

  modport source (output valid, output kind, output address_high, output address_low,
                  output status, output address_count, output last, input ready);
  modport sink   (input valid, input kind, input address_high, input address_low,
                  input status, input address_count, input last, output ready);
endinterface

/* hw/rtl/dae_parse.sv */
`timescale 1ns / 1ps
// Byte-at-a-time DNS response parser: header, question skip, answer records.
// Depends on dae_pkg. Produces up to two results per accepted byte.
module dae_parse
  import dae_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 1500
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [15:0] expected_id_i,
  output push_t       push_o
);

  localparam int unsigned PosW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_PACKET_BYTES);

  logic [PosW-1:0] pos_q, pos_d;
  phase_e          phase_q, phase_d;
  logic            id_ok_q, id_ok_d;
  logic [7:0]      id_low_q, id_low_d;
  logic [15:0]     quest_q, quest_d;
  logic [15:0]     ans_q, ans_d;
  logic [7:0]      lbl_q, lbl_d;
  logic [15:0]     fld_q, fld_d;
  logic [15:0]     rtype_q, rtype_d;
  logic [15:0]     rlen_q, rlen_d;
  logic [15:0]     found_q, found_d;
  // last 15 bytes of rdata; the 16th comes straight from the input
  logic [119:0]    shift_q, shift_d;

  logic            name_ptr, name_end;
  logic [15:0]     rlen_now;
  logic [15:0]     ans_dec, quest_dec;
  logic            addr_out;
  res_t            addr_res, stat_res;
  status_e         stat;

  // Name walking: a pointer or a terminating zero only when no label is open
  assign name_ptr  = (lbl_q == 8'd0) && ((data_byte_i & PtrMask) == PtrMask);
  assign name_end  = (lbl_q == 8'd0) && (data_byte_i == 8'd0);
  assign ans_dec   = ans_q - 16'd1;
  assign quest_dec = quest_q - 16'd1;
  assign rlen_now  = (fld_q == 16'd1) ? {rlen_q[15:8], data_byte_i} : rlen_q;

  // Next-state logic for one byte
  always_comb begin
    pos_d    = pos_q;
    phase_d  = phase_q;
    id_ok_d  = id_ok_q;
    id_low_d = id_low_q;
    quest_d  = quest_q;
    ans_d    = ans_q;
    lbl_d    = lbl_q;
    fld_d    = fld_q;
    rtype_d  = rtype_q;
    rlen_d   = rlen_q;
    found_d  = found_q;
    shift_d  = shift_q;
    addr_out = 1'b0;
    addr_res = '0;
    stat_res = '0;
    stat     = ST_OK;

    if (take_i && (pos_q < PosMax)) begin
      pos_d = pos_q + PosW'(1);
      case (phase_q)
        PH_HEADER: begin
          if (pos_q == PosW'(0)) begin
            id_ok_d  = (data_byte_i == expected_id_i[15:8]);
            id_low_d = expected_id_i[7:0];
          end else if (pos_q == PosW'(1)) begin
            id_ok_d = id_ok_q && (data_byte_i == id_low_q);
            if (!(id_ok_q && (data_byte_i == id_low_q))) begin
              phase_d = PH_IGNORE;
            end
          end else if (pos_q == PosW'(4)) begin
            quest_d = {data_byte_i, 8'd0};
          end else if (pos_q == PosW'(5)) begin
            quest_d = {quest_q[15:8], data_byte_i};
          end else if (pos_q == PosW'(6)) begin
            ans_d = {data_byte_i, 8'd0};
          end else if (pos_q == PosW'(7)) begin
            ans_d = {ans_q[15:8], data_byte_i};
          end else if (pos_q == PosW'(HdrLen - 1)) begin
            lbl_d = 8'd0;
            if (quest_q != 16'd0) begin
              phase_d = PH_QNAME;
            end else begin
              phase_d = (ans_q != 16'd0) ? PH_ANAME : PH_DONE;
            end
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (lbl_q != 8'd0) begin
            lbl_d = lbl_q - 8'd1;
          end else if (name_ptr) begin
            phase_d = (phase_q == PH_QNAME) ? PH_QPTR : PH_APTR;
          end else if (name_end) begin
            phase_d = (phase_q == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
            fld_d   = (phase_q == PH_QNAME) ? 16'(QFixLen) : 16'(AFixLen);
          end else begin
            lbl_d = data_byte_i;
          end
        end
        PH_QPTR: begin
          phase_d = PH_QFIXED;
          fld_d   = 16'(QFixLen);
        end
        PH_APTR: begin
          phase_d = PH_AFIXED;
          fld_d   = 16'(AFixLen);
        end
        PH_QFIXED: begin
          fld_d = fld_q - 16'd1;
          if (fld_q == 16'd1) begin
            quest_d = quest_dec;
            lbl_d   = 8'd0;
            if (quest_dec != 16'd0) begin
              phase_d = PH_QNAME;
            end else begin
              phase_d = (ans_q != 16'd0) ? PH_ANAME : PH_DONE;
            end
          end
        end
        PH_AFIXED: begin
          // type in the first two bytes, rdlength in the last two
          if (fld_q == 16'(AFixLen)) begin
            rtype_d = {data_byte_i, 8'd0};
          end else if (fld_q == 16'(AFixLen - 1)) begin
            rtype_d = {rtype_q[15:8], data_byte_i};
          end else if (fld_q == 16'd2) begin
            rlen_d = {data_byte_i, 8'd0};
          end else if (fld_q == 16'd1) begin
            rlen_d = rlen_now;
          end
          fld_d = fld_q - 16'd1;
          if (fld_q == 16'd1) begin
            if (rlen_now == 16'd0) begin
              ans_d   = ans_dec;
              lbl_d   = 8'd0;
              phase_d = (ans_dec != 16'd0) ? PH_ANAME : PH_DONE;
            end else begin
              fld_d   = rlen_now;
              phase_d = PH_RDATA;
            end
          end
        end
        PH_RDATA: begin
          shift_d = {shift_q[111:0], data_byte_i};
          fld_d   = fld_q - 16'd1;
          if (fld_q == 16'd1) begin
            if ((rtype_q == TypeV4) && (rlen_q == LenV4)) begin
              addr_out             = 1'b1;
              addr_res.kind        = KIND_V4;
              addr_res.address_low = {32'd0, shift_q[23:0], data_byte_i};
            end else if ((rtype_q == TypeV6) && (rlen_q == LenV6)) begin
              addr_out              = 1'b1;
              addr_res.kind         = KIND_V6;
              addr_res.address_high = shift_q[119:56];
              addr_res.address_low  = {shift_q[55:0], data_byte_i};
            end
            if (addr_out && (found_q != 16'hFFFF)) begin
              found_d = found_q + 16'd1;
            end
            ans_d   = ans_dec;
            lbl_d   = 8'd0;
            phase_d = (ans_dec != 16'd0) ? PH_ANAME : PH_DONE;
          end
        end
        default: ;
      endcase
    end

    // End of packet: status from the state after this byte, then back to reset
    if (take_i && last_byte_i) begin
      if (pos_d < PosW'(HdrLen)) begin
        stat = ST_SHORT_HDR;
      end else if (!id_ok_d) begin
        stat = ST_ID_MISMATCH;
      end else if (phase_d == PH_DONE) begin
        stat = ST_OK;
      end else if ((phase_d == PH_ANAME) || (phase_d == PH_APTR) ||
                   (phase_d == PH_AFIXED) || (phase_d == PH_RDATA)) begin
        stat = ST_ANSWER_CUT;
      end else begin
        stat = ST_BAD_QUEST;
      end
      stat_res.kind          = KIND_STATUS;
      stat_res.status        = stat;
      stat_res.address_count = found_d;
      stat_res.last          = 1'b1;

      pos_d    = '0;
      phase_d  = PH_HEADER;
      id_ok_d  = 1'b0;
      id_low_d = 8'd0;
      quest_d  = 16'd0;
      ans_d    = 16'd0;
      lbl_d    = 8'd0;
      fld_d    = 16'd0;
      rtype_d  = 16'd0;
      rlen_d   = 16'd0;
      found_d  = 16'd0;
    end
  end

  // Results handed to the queue in order: address first, then status
  always_comb begin
    push_o = '0;
    if (addr_out) begin
      push_o.res0 = addr_res;
      push_o.res1 = stat_res;
      push_o.cnt  = (take_i && last_byte_i) ? 2'd2 : 2'd1;
    end else if (take_i && last_byte_i) begin
      push_o.res0 = stat_res;
      push_o.cnt  = 2'd1;
    end
  end

  // Parser control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= PH_HEADER;
      id_ok_q  <= 1'b0;
      id_low_q <= 8'd0;
      quest_q  <= 16'd0;
      ans_q    <= 16'd0;
      lbl_q    <= 8'd0;
      fld_q    <= 16'd0;
      rtype_q  <= 16'd0;
      rlen_q   <= 16'd0;
      found_q  <= 16'd0;
    end else begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      id_ok_q  <= id_ok_d;
      id_low_q <= id_low_d;
      quest_q  <= quest_d;
      ans_q    <= ans_d;
      lbl_q    <= lbl_d;
      fld_q    <= fld_d;
      rtype_q  <= rtype_d;
      rlen_q   <= rlen_d;
      found_q  <= found_d;
    end
  end

  // Address shift line; always fully refilled before it is read
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

endmodule

/* hw/rtl/dae_out_fifo.sv */
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on dae_pkg.
module dae_out_fifo
  import dae_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room2_o,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  res_o
);

  localparam int unsigned PtrW = $clog2(OutDepth);
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  res_t            mem_q [OutDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  logic [PtrW-1:0] wr_next;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign res_o   = mem_q[rd_q];
  assign room2_o = (cnt_q <= CntW'(OutDepth - 2));
  assign wr_next = wr_q + PtrW'(1);

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.cnt);
    rd_d  = pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.cnt) - (pop ? CntW'(1) : CntW'(0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.res1;
    end
  end

endmodule

/* hw/rtl/dns_answer_address_extractor.sv */
`timescale 1ns / 1ps
// Top level of the DNS answer address extractor.
// Depends on dae_pkg, dae_in_if, dae_out_if, dae_parse and dae_out_fifo.

// Takes a DNS response one byte per cycle and returns every complete A and AAAA
// address in its answers, followed by one status result when the byte flagged
// last arrives. Each accepted byte is parsed in the cycle of its transfer and its
// results are offered from the next cycle on through a four-entry result queue.
// The input stays ready while the queue has two free entries, so a byte stream
// runs at one byte per clock as long as results are taken; only a byte that
// completes an address and also ends the packet produces two results, which the
// queue absorbs. Bytes at or past MAX_PACKET_BYTES are not parsed, but their last
// flag still closes the packet. The expected id is sampled with the first byte.
module dns_answer_address_extractor
  import dae_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 1500
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  dae_in_if.sink     in_i,
  dae_out_if.source  out_o
);

  logic  take;
  logic  room2;
  push_t push;
  res_t  res;

  assign in_i.ready = room2;
  assign take       = in_i.valid && room2;

  // Byte parser
  dae_parse #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .data_byte_i   (in_i.data_byte),
    .last_byte_i   (in_i.last_byte),
    .expected_id_i (in_i.expected_id),
    .push_o        (push)
  );

  // Result queue
  dae_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room2_o (room2),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.kind          = res.kind;
  assign out_o.address_high  = res.address_high;
  assign out_o.address_low   = res.address_low;
  assign out_o.status        = res.status;
  assign out_o.address_count = res.address_count;
  assign out_o.last          = res.last;

endmodule

/* dv/tb_dns_answer_address_extractor.sv */
`timescale 1ns / 1ps
// Testbench for dns_answer_address_extractor: directed and random DNS responses in,
// addresses and per-packet status checked against a byte-level parser kept here.
// Depends on dae_pkg, dae_in_if, dae_out_if and the extractor RTL.
module tb_dns_answer_address_extractor
  import dae_pkg::*;
();

  localparam int unsigned MaxBytes    = 1500;
  localparam int unsigned PhaseBytes  = 96;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned TailCycles  = 16;
  localparam int unsigned ReportMax   = 10;
  // enough records for a long packet that still stays under the packet limit
  localparam int unsigned LongAnswers = 88;

  typedef enum {NAME_MORE, NAME_END, NAME_PTR} name_step_e;
  typedef enum {REC_A, REC_AAAA, REC_A_BADLEN, REC_AAAA_BADLEN, REC_OTHER} rec_kind_e;
  typedef enum {PKT_GOOD, PKT_CUT, PKT_BAD_ID, PKT_NOISE} pkt_shape_e;

  // Parser copy plus the queue of addresses and statuses still to come out
  class address_scoreboard;
    res_t         awaited[$];
    int unsigned  mismatches;
    int unsigned  byte_pos;
    phase_e       phase;
    bit           id_ok;
    logic [7:0]   id_lo;
    logic [7:0]   label_left;
    logic [15:0]  quest_left;
    logic [15:0]  ans_left;
    logic [15:0]  field_left;
    logic [15:0]  rec_type;
    logic [15:0]  rec_len;
    logic [15:0]  found;
    logic [127:0] shift;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      byte_pos   = 0;
      phase      = PH_HEADER;
      id_ok      = 1'b0;
      id_lo      = '0;
      label_left = '0;
      quest_left = '0;
      ans_left   = '0;
      field_left = '0;
      rec_type   = '0;
      rec_len    = '0;
      found      = '0;
      shift      = '0;
    endfunction

    function void give(kind_e k, logic [127:0] addr, status_e st, logic lst);
      res_t r;
      r.kind          = k;
      r.address_high  = addr[127:64];
      r.address_low   = addr[63:0];
      r.status        = st;
      r.address_count = lst ? found : 16'd0;
      r.last          = lst;
      awaited.insert(awaited.size(), r);
    endfunction

    // One byte of a name: label length, label content, terminator or pointer
    function name_step_e walk_name(logic [7:0] b);
      if (label_left != 0) begin
        label_left--;
        return NAME_MORE;
      end
      if ((b & PtrMask) == PtrMask) return NAME_PTR;
      if (b == 8'd0) return NAME_END;
      label_left = b;
      return NAME_MORE;
    endfunction

    function void open_answers();
      label_left = '0;
      phase = (ans_left != 0) ? PH_ANAME : PH_DONE;
    endfunction

    function void close_answer();
      ans_left--;
      open_answers();
    endfunction

    function void parse_byte(int unsigned idx, logic [7:0] b, logic [15:0] eid);
      name_step_e  ns;
      int unsigned k;
      case (phase)
        PH_HEADER: begin
          if (idx == 0) begin
            id_ok = (b == eid[15:8]);
            id_lo = eid[7:0];
          end else if (idx == 1) begin
            id_ok = id_ok && (b == id_lo);
            if (!id_ok) phase = PH_IGNORE;
          end else if (idx == 4) quest_left = {b, 8'h00};
          else if (idx == 5) quest_left = quest_left | {8'h00, b};
          else if (idx == 6) ans_left = {b, 8'h00};
          else if (idx == 7) ans_left = ans_left | {8'h00, b};
          else if (idx == HdrLen - 1) begin
            label_left = '0;
            if (quest_left != 0) phase = PH_QNAME;
            else open_answers();
          end
        end
        PH_QNAME: begin
          ns = walk_name(b);
          if (ns == NAME_PTR) phase = PH_QPTR;
          else if (ns == NAME_END) begin
            phase = PH_QFIXED;
            field_left = 16'(QFixLen);
          end
        end
        PH_QPTR: begin
          phase = PH_QFIXED;
          field_left = 16'(QFixLen);
        end
        PH_QFIXED: begin
          field_left--;
          if (field_left == 0) begin
            quest_left--;
            label_left = '0;
            if (quest_left != 0) phase = PH_QNAME;
            else open_answers();
          end
        end
        PH_ANAME: begin
          ns = walk_name(b);
          if (ns == NAME_PTR) phase = PH_APTR;
          else if (ns == NAME_END) begin
            phase = PH_AFIXED;
            field_left = 16'(AFixLen);
          end
        end
        PH_APTR: begin
          phase = PH_AFIXED;
          field_left = 16'(AFixLen);
        end
        // type, class, ttl, rdlength
        PH_AFIXED: begin
          k = AFixLen - field_left;
          if (k == 0) rec_type = {b, 8'h00};
          else if (k == 1) rec_type = rec_type | {8'h00, b};
          else if (k == 8) rec_len = {b, 8'h00};
          else if (k == 9) rec_len = rec_len | {8'h00, b};
          field_left--;
          if (field_left == 0) begin
            shift = '0;
            if (rec_len == 0) close_answer();
            else begin
              field_left = rec_len;
              phase = PH_RDATA;
            end
          end
        end
        PH_RDATA: begin
          shift = {shift[119:0], b};
          field_left--;
          if (field_left == 0) begin
            if (rec_type == TypeV4 && rec_len == LenV4) begin
              give(KIND_V4, {96'd0, shift[31:0]}, ST_OK, 1'b0);
              if (found != 16'hFFFF) found++;
            end else if (rec_type == TypeV6 && rec_len == LenV6) begin
              give(KIND_V6, shift, ST_OK, 1'b0);
              if (found != 16'hFFFF) found++;
            end
            close_answer();
          end
        end
        default: ;
      endcase
    endfunction

    // Accepted input transfer: parse it, close the packet on its last byte
    function void take_byte(logic [7:0] b, logic lst, logic [15:0] eid);
      status_e     st;
      int unsigned idx;
      if (byte_pos < MaxBytes) begin
        idx = byte_pos;
        byte_pos++;
        parse_byte(idx, b, eid);
      end
      if (lst) begin
        if (byte_pos < HdrLen) st = ST_SHORT_HDR;
        else if (!id_ok) st = ST_ID_MISMATCH;
        else if (phase == PH_DONE) st = ST_OK;
        else if (phase inside {PH_ANAME, PH_APTR, PH_AFIXED, PH_RDATA}) st = ST_ANSWER_CUT;
        else st = ST_BAD_QUEST;
        give(KIND_STATUS, '0, st, 1'b1);
        clear();
      end
    endfunction

    function void show(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) $display("  %-13s expected %h, got %h", name, want, got);
    endfunction

    // Accepted output transfer against the oldest expectation
    function void match_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("%0t: result with none expected: kind %0d status %0d", $time,
                   got.kind, got.status);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= ReportMax) begin
          $display("%0t: result mismatch", $time);
          show("kind", 64'(want.kind), 64'(got.kind));
          show("address_high", want.address_high, got.address_high);
          show("address_low", want.address_low, got.address_low);
          show("status", 64'(want.status), 64'(got.status));
          show("address_count", 64'(want.address_count), 64'(got.address_count));
          show("last", 64'(want.last), 64'(got.last));
        end
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dae_in_if  in_if();
  dae_out_if out_if();

  dns_answer_address_extractor #(.MAX_PACKET_BYTES(MaxBytes)) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  address_scoreboard sb = new();

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned holds_asked  = 0;
  int unsigned holds_done   = 0;
  int unsigned hold_left    = 0;
  int unsigned cycles       = 0;
  int unsigned bytes_sent   = 0;
  logic [7:0]  pkt[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_asked;
      hold_left <= HoldCycles;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watch both channels; the cycle count bounds the run
  always @(posedge clk) begin : watch
    res_t seen;
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("** dns_answer_address_extractor: FAILED **");
      $finish;
    end else if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.take_byte(in_if.data_byte, in_if.last_byte, in_if.expected_id);
      if (out_if.valid && out_if.ready) begin
        seen.kind          = out_if.kind;
        seen.address_high  = out_if.address_high;
        seen.address_low   = out_if.address_low;
        seen.status        = out_if.status;
        seen.address_count = out_if.address_count;
        seen.last          = out_if.last;
        sb.match_result(seen);
      end
    end
  end

  // One byte transfer, after random idle cycles
  task automatic send_byte(input logic [7:0] b, input logic lst, input logic [15:0] eid);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.last_byte   <= lst;
    in_if.expected_id <= eid;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Expected id only matters on the first byte; the rest carry noise there
  task automatic send_packet(input logic [15:0] eid);
    for (int i = 0; i < pkt.size(); i++)
      send_byte(pkt[i], i == pkt.size() - 1, (i == 0) ? eid : 16'($urandom));
    bytes_sent += pkt.size();
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
  endtask

  function automatic void push16(logic [15:0] v);
    pkt.insert(pkt.size(), v[15:8]);
    pkt.insert(pkt.size(), v[7:0]);
  endfunction

  function automatic void push_random(int unsigned n);
    repeat (n) pkt.insert(pkt.size(), 8'($urandom));
  endfunction

  // Labels (now and then a 0x40..0xBF length), ending in a zero or a pointer
  function automatic void push_name();
    int unsigned labels;
    int unsigned len;
    labels = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 3);
    repeat (labels) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(64, 191) : $urandom_range(1, 12);
      pkt.insert(pkt.size(), 8'(len));
      push_random(len);
    end
    if ($urandom_range(2) == 0) begin
      pkt.insert(pkt.size(), PtrMask | 8'($urandom_range(63)));
      push_random(1);
    end else begin
      pkt.insert(pkt.size(), 8'h00);
    end
  endfunction

  function automatic void push_answer();
    rec_kind_e   rk;
    logic [15:0] rtype;
    logic [15:0] rlen;
    int unsigned pick;
    int unsigned body;
    push_name();
    pick = $urandom_range(99);
    rk = (pick < 35) ? REC_A : (pick < 65) ? REC_AAAA : (pick < 75) ? REC_A_BADLEN :
         (pick < 85) ? REC_AAAA_BADLEN : REC_OTHER;
    case (rk)
      REC_A: begin
        rtype = TypeV4;
        rlen  = LenV4;
      end
      REC_AAAA: begin
        rtype = TypeV6;
        rlen  = LenV6;
      end
      REC_A_BADLEN: begin
        rtype = TypeV4;
        rlen  = $urandom_range(1) ? 16'($urandom_range(5, 24)) : 16'($urandom_range(3));
      end
      REC_AAAA_BADLEN: begin
        rtype = TypeV6;
        rlen  = $urandom_range(1) ? 16'($urandom_range(17, 24)) : 16'($urandom_range(15));
      end
      default: begin
        rtype = 16'($urandom);
        // a huge rdlength runs past the end of the packet
        rlen  = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(24));
      end
    endcase
    push16(rtype);
    push_random(6);
    push16(rlen);
    body = (rlen > 24) ? $urandom_range(24) : rlen;
    push_random(body);
  endfunction

  // Well-formed response, sometimes with counts that disagree with the body
  function automatic void build_response(logic [15:0] id);
    int unsigned q_real;
    int unsigned a_real;
    logic [15:0] q_hdr;
    logic [15:0] a_hdr;
    pkt.delete();
    q_real = $urandom_range(2);
    a_real = $urandom_range(4);
    q_hdr  = 16'(q_real);
    a_hdr  = 16'(a_real);
    case ($urandom_range(11))
      0: q_hdr = 16'hFFFF;
      1: a_hdr = 16'hFFFF;
      2: a_hdr = 16'(a_real + $urandom_range(1, 3));
      3: q_hdr = 16'(q_real + 1);
      4: a_hdr = (a_real != 0) ? 16'(a_real - 1) : 16'd0;
      default: ;
    endcase
    push16(id);
    push_random(2);
    push16(q_hdr);
    push16(a_hdr);
    push_random(4);
    repeat (q_real) begin
      push_name();
      push_random(4);
    end
    repeat (a_real) push_answer();
    if ($urandom_range(4) == 0) push_random($urandom_range(1, 8));
  endfunction

  task automatic random_packet();
    pkt_shape_e  shape;
    logic [15:0] id;
    logic [15:0] eid;
    int unsigned pick;
    int unsigned cut;
    pick  = $urandom_range(99);
    shape = (pick < 60) ? PKT_GOOD : (pick < 75) ? PKT_CUT : (pick < 85) ? PKT_BAD_ID :
            PKT_NOISE;
    id  = 16'($urandom);
    eid = id;
    if (shape == PKT_NOISE) begin
      pkt.delete();
      push_random($urandom_range(1, 30));
      eid = 16'($urandom);
      if (pkt.size() > 1 && $urandom_range(1) == 1) eid = {pkt[0], pkt[1]};
    end else begin
      build_response(id);
    end
    // id off in the high or in the low byte
    if (shape == PKT_BAD_ID)
      eid = id ^ (16'($urandom_range(1, 255)) << ($urandom_range(1) ? 8 : 0));
    if (shape == PKT_CUT || (shape == PKT_BAD_ID && $urandom_range(1) == 1)) begin
      cut = $urandom_range(1, pkt.size());
      pkt = pkt[0:cut-1];
    end
    send_packet(eid);
  endtask

  // Many A records, a long packet that stays just under the packet limit
  task automatic long_packet();
    logic [15:0] id;
    id = 16'($urandom);
    pkt.delete();
    push16(id);
    push_random(2);
    push16(16'd1);
    push16(16'(LongAnswers));
    push_random(4);
    pkt.insert(pkt.size(), PtrMask);
    push_random(5);
    repeat (LongAnswers) begin
      pkt.insert(pkt.size(), PtrMask);
      push_random(1);
      push16(TypeV4);
      push_random(6);
      push16(LenV4);
      push_random(4);
    end
    send_packet(id);
  endtask

  initial begin
    int unsigned budget;
    in_if.valid       = 1'b0;
    in_if.data_byte   = '0;
    in_if.last_byte   = 1'b0;
    in_if.expected_id = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one-byte packet, id mismatch on all-ones, empty good header
    pkt = '{8'hFF};
    send_packet(16'hFFFF);
    pkt.delete();
    repeat (12) pkt.insert(pkt.size(), 8'hFF);
    send_packet(16'h0000);
    pkt.delete();
    repeat (12) pkt.insert(pkt.size(), 8'h00);
    send_packet(16'h0000);
    wait_drained();

    // Random traffic under four idle patterns
    for (int phase_no = 0; phase_no < 4; phase_no++) begin
      case (phase_no)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
        default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
      endcase
      budget = bytes_sent + PhaseBytes;
      while (bytes_sent < budget) random_packet();
      if (phase_no == 0) begin
        // fill the result queue while the receiver holds off
        holds_asked++;
        long_packet();
      end
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0)
      $display("** dns_answer_address_extractor: PASSED **");
    else
      $display("** dns_answer_address_extractor: FAILED **");
    $finish;
  end

endmodule
